// File: hw/rtl/stwa_pkg.sv
// Package with the types and constants of the session table with aging.
`default_nettype none

package stwa_pkg;

  localparam int ADDR_W = 32;
  localparam int ID_W = 16;
  localparam int TIME_W = 32;
  localparam int LEN_W = 16;
  localparam int FLAGS_W = 8;
  localparam int EVENT_W = 3;
  localparam int COUNT_W = 5;
  localparam int EVCNT_W = 5;

  localparam logic [LEN_W-1:0] MIN_PACKET_LEN = 16'd28;
  localparam int DELETE_BIT = 2;
  localparam logic [EVCNT_W-1:0] MAX_EVENTS = 5'd16;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300000;
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [EVENT_W-1:0] EV_REFRESHED = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DISCOVERED = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DELETED = 3'd2;
  localparam logic [EVENT_W-1:0] EV_EXPIRED = 3'd3;
  localparam logic [EVENT_W-1:0] EV_FULL = 3'd4;
  localparam logic [EVENT_W-1:0] EV_MALFORMED = 3'd5;
  localparam logic [EVENT_W-1:0] EV_NOTHING = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] seen;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LK_RD,
    ST_LK_CHK,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_TK_NEXT,
    ST_TK_CHK,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/stwa_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module stwa_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/session_table_with_aging_top.sv
// Top level of the session table with aging: sequencer, datapath and register port.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid / in_ready  | command, header_flags, message_id,
//           |                      | source_address, packet_length, type_matches,
//           |                      | current_time
//  output   | out_valid / out_ready| event_res, entry_address, entry_id,
//           |                      | entry_count, last
//  config   | APB psel / penable   | paddr, pwdata, prdata (expiry timeout)
//
// The single table RAM is walked entry by entry for lookup, expiry scan and compaction.
// A tick is slowest when the expired half lies below the fresh half; output stalls lengthen it.
// Reset empties the table by clearing the occupancy count; the RAM itself is never cleared.
// A new item is taken only when the sequencer is idle; one result may still wait at the output.
// An output stall holds the sequencer at its next result.
`default_nettype none

module session_table_with_aging_top import stwa_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic [FLAGS_W-1:0] header_flags,
  input  wire logic [ID_W-1:0]    message_id,
  input  wire logic [ADDR_W-1:0]  source_address,
  input  wire logic [LEN_W-1:0]   packet_length,
  input  wire logic               type_matches,
  input  wire logic [TIME_W-1:0]  current_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [EVENT_W-1:0] event_res,
  output logic      [ADDR_W-1:0]  entry_address,
  output logic      [ID_W-1:0]    entry_id,
  output logic      [COUNT_W-1:0] entry_count,
  output logic                    last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] ONE = CW'(1);

  state_t state, state_next;

  logic              item_del;
  logic              item_tick;
  logic [ID_W-1:0]   item_id;
  logic [ADDR_W-1:0] item_addr;
  logic [TIME_W-1:0] item_now;
  logic [TIME_W-1:0] timeout;
  logic [CW-1:0]     occ;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     scan;
  logic [EVCNT_W-1:0] n_ev;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [ID_W-1:0]   pend_id;
  logic [CW-1:0]     pend_cnt;
  logic [ADDR_W-1:0] cand_addr;
  logic [ID_W-1:0]   cand_id;
  logic [EVENT_W-1:0] res_event;
  logic [ADDR_W-1:0] res_addr;
  logic [ID_W-1:0]   res_id;
  logic [CW-1:0]     res_cnt;
  logic              res_last;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [IW-1:0]     ram_raddr;
  entry_t            ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t            rd;

  logic              malformed;
  logic              key_hit;
  logic              aged;
  logic [CW-1:0]     ptr_inc;
  logic [CW-1:0]     scan_dec;
  logic              compact_done;
  logic              scan_done;
  logic              out_free;
  logic              out_load;
  logic              cfg_write;
  entry_t            item_entry;

  stwa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);
  assign item_entry = '{address: item_addr, id: item_id, seen: item_now};
  assign malformed = (packet_length < MIN_PACKET_LEN) || !type_matches;
  assign key_hit = (rd.address == item_addr) && (rd.id == item_id);
  assign aged = (item_now - rd.seen) >= timeout;
  assign ptr_inc = ptr + ONE;
  assign scan_dec = scan - ONE;
  assign compact_done = ptr_inc >= occ;
  assign scan_done = (scan == '0) || (n_ev == MAX_EVENTS);
  assign out_free = !out_valid || out_ready;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout : 32'd0;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (command) begin
            state_next = ST_TK_NEXT;
          end else if (malformed) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_LK_RD;
          end
        end
      end
      ST_LK_RD: begin
        state_next = (ptr == occ) ? ST_EMIT : ST_LK_CHK;
      end
      ST_LK_CHK: begin
        if (key_hit) begin
          state_next = item_del ? ST_DEL_RD : ST_EMIT;
        end else begin
          state_next = ST_LK_RD;
        end
      end
      ST_DEL_RD: begin
        if (compact_done) begin
          if (item_tick) begin
            state_next = pend ? ST_EMIT : ST_TK_NEXT;
          end else begin
            state_next = ST_EMIT;
          end
        end else begin
          state_next = ST_DEL_WR;
        end
      end
      ST_DEL_WR: begin
        state_next = ST_DEL_RD;
      end
      ST_TK_NEXT: begin
        state_next = scan_done ? ST_EMIT : ST_TK_CHK;
      end
      ST_TK_CHK: begin
        state_next = aged ? ST_DEL_RD : ST_TK_NEXT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = res_last ? ST_IDLE : ST_TK_NEXT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ptr[IW-1:0];
    ram_wdata = item_entry;
    ram_raddr = ptr[IW-1:0];
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LK_RD: begin
        if ((ptr == occ) && !item_del && (occ < FULL_COUNT)) begin
          ram_we    = 1'b1;
          ram_waddr = occ[IW-1:0];
        end
      end
      ST_LK_CHK: begin
        ram_we = key_hit && !item_del;
      end
      ST_DEL_RD: begin
        ram_raddr = ptr_inc[IW-1:0];
      end
      ST_DEL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rd;
      end
      ST_TK_NEXT: begin
        ram_raddr = scan_dec[IW-1:0];
      end
      ST_TK_CHK: begin
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      timeout   <= TIMEOUT_RESET;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write && (paddr[2] == REG_TIMEOUT)) begin
        timeout <= pwdata;
      end
      if (out_load) begin
        out_valid     <= 1'b1;
        event_res     <= res_event;
        entry_address <= res_addr;
        entry_id      <= res_id;
        entry_count   <= COUNT_W'(res_cnt);
        last          <= res_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item_del  <= header_flags[DELETE_BIT];
            item_tick <= command;
            item_id   <= message_id;
            item_addr <= source_address;
            item_now  <= current_time;
            ptr       <= '0;
            scan      <= occ;
            n_ev      <= '0;
            pend      <= 1'b0;
            res_event <= EV_MALFORMED;
            res_addr  <= '0;
            res_id    <= '0;
            res_cnt   <= occ;
            res_last  <= 1'b1;
          end
        end
        ST_LK_RD: begin
          if (ptr == occ) begin
            res_last <= 1'b1;
            if (item_del) begin
              res_event <= EV_NOTHING;
              res_addr  <= '0;
              res_id    <= '0;
              res_cnt   <= occ;
            end else if (occ >= FULL_COUNT) begin
              res_event <= EV_FULL;
              res_addr  <= item_addr;
              res_id    <= item_id;
              res_cnt   <= occ;
            end else begin
              occ       <= occ + ONE;
              res_event <= EV_DISCOVERED;
              res_addr  <= item_addr;
              res_id    <= item_id;
              res_cnt   <= occ + ONE;
            end
          end
        end
        ST_LK_CHK: begin
          if (key_hit) begin
            res_event <= EV_REFRESHED;
            res_addr  <= item_addr;
            res_id    <= item_id;
            res_cnt   <= occ;
            res_last  <= 1'b1;
          end else begin
            ptr <= ptr_inc;
          end
        end
        ST_DEL_RD: begin
          if (compact_done) begin
            occ <= occ - ONE;
            if (!item_tick) begin
              res_event <= EV_DELETED;
              res_addr  <= item_addr;
              res_id    <= item_id;
              res_cnt   <= occ - ONE;
              res_last  <= 1'b1;
            end else begin
              n_ev      <= n_ev + EVCNT_W'(1);
              res_event <= EV_EXPIRED;
              res_addr  <= pend_addr;
              res_id    <= pend_id;
              res_cnt   <= pend_cnt;
              res_last  <= 1'b0;
              pend      <= 1'b1;
              pend_addr <= cand_addr;
              pend_id   <= cand_id;
              pend_cnt  <= occ - ONE;
            end
          end
        end
        ST_DEL_WR: begin
          ptr <= ptr_inc;
        end
        ST_TK_NEXT: begin
          if (scan_done) begin
            res_last <= 1'b1;
            if (pend) begin
              res_event <= EV_EXPIRED;
              res_addr  <= pend_addr;
              res_id    <= pend_id;
              res_cnt   <= pend_cnt;
            end else begin
              res_event <= EV_NOTHING;
              res_addr  <= '0;
              res_id    <= '0;
              res_cnt   <= occ;
            end
          end else begin
            scan <= scan_dec;
          end
        end
        ST_TK_CHK: begin
          if (aged) begin
            cand_addr <= rd.address;
            cand_id   <= rd.id;
            ptr       <= scan;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_COUNT)
    else $error("Table occupancy exceeds its depth.");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (occ != $past(occ)) |-> ((occ == $past(occ) + ONE) || (occ + ONE == $past(occ))))
    else $error("Table occupancy changed by more than one entry in a cycle.");

  a_only_expiry_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (event_res == EV_EXPIRED))
    else $error("A result that is not the last of its item is not an expiry.");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == ST_LK_RD) || (state == ST_LK_CHK) || (state == ST_DEL_WR)))
    else $error("Table written outside lookup or compaction.");

endmodule

`default_nettype wire
